// ===== design/lkv_pkg.sv =====
package lkv_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CAP_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(ENTRIES);
    localparam logic             REG_CAPACITY   = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic is_get;
        logic out_busy;
    } sts_t;

endpackage

// ===== design/lru_key_value_cache.sv =====
// Fully associative 16-entry key/value cache with LRU replacement. Each input
// beat is a get (s_tuser = 0) or a put (s_tuser = 1); a get answers with one
// output beat (hit flag on m_tuser, value or all ones on m_tdata), a put gives
// none. Each item passes through an accept state, a scan that compares one
// stored key per cycle, and a commit state that updates all recency ranks at
// once. A get commit waits while the previous result beat is still held in the
// output register. The store is empty right after reset (no clearing pass). The
// capacity register (address 0) may only be written while the block is idle;
// 0 acts as 1 and stored values above 16 act as 16.
module lru_key_value_cache (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // [31:0] key, [63:32] value
    input  logic        s_tuser,  // [0] kind
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // [31:0] read_value
    output logic        m_tuser   // [0] hit
);

    logic [lkv_pkg::CAP_W-1:0] capacity_reg;
    logic                      cfg_write;
    lkv_pkg::cmd_t             cmd;
    lkv_pkg::sts_t             sts;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= lkv_pkg::CAPACITY_RESET;
        end else if (cfg_write && (paddr[2] == lkv_pkg::REG_CAPACITY)) begin
            capacity_reg <= pwdata[lkv_pkg::CAP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == lkv_pkg::REG_CAPACITY)
                  ? {{(32 - lkv_pkg::CAP_W){1'b0}}, capacity_reg} : 32'd0;

    lkv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lkv_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .capacity  (capacity_reg),
        .in_kind   (s_tuser),
        .in_key    (s_tdata[31:0]),
        .in_value  (s_tdata[63:32]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_hit   (m_tuser),
        .out_value (m_tdata)
    );

    a_load_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (s_tvalid && s_tready))
        else $error("load without input beat");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> !s_tready)
        else $error("input ready during scan");

    a_commit_not_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !(sts.is_get && sts.out_busy))
        else $error("get committed over a held result");

    a_result_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.commit && sts.is_get))
        else $error("result beat without get commit");

endmodule

// ===== design/lkv_ctrl.sv =====
module lkv_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  lkv_pkg::sts_t sts,
    output lkv_pkg::cmd_t cmd
);

    lkv_pkg::state_t state_reg;
    lkv_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lkv_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lkv_pkg::ST_IDLE: begin
                if (in_valid) begin
                    state_next = lkv_pkg::ST_SCAN;
                end
            end
            lkv_pkg::ST_SCAN: begin
                if (sts.scan_last) begin
                    state_next = lkv_pkg::ST_COMMIT;
                end
            end
            lkv_pkg::ST_COMMIT: begin
                if (!(sts.is_get && sts.out_busy)) begin
                    state_next = lkv_pkg::ST_IDLE;
                end
            end
            default: state_next = lkv_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.commit    = 1'b0;
        unique case (state_reg)
            lkv_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            lkv_pkg::ST_SCAN: begin
                cmd.scan_step = 1'b1;
            end
            lkv_pkg::ST_COMMIT: begin
                cmd.commit = !(sts.is_get && sts.out_busy);
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/lkv_datapath.sv =====
module lkv_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lkv_pkg::cmd_t               cmd,
    output lkv_pkg::sts_t               sts,
    input  logic [lkv_pkg::CAP_W-1:0]   capacity,
    input  logic                        in_kind,
    input  logic [lkv_pkg::KEY_W-1:0]   in_key,
    input  logic [lkv_pkg::VAL_W-1:0]   in_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        out_hit,
    output logic [lkv_pkg::VAL_W-1:0]   out_value
);

    localparam int N  = lkv_pkg::ENTRIES;
    localparam int IW = lkv_pkg::IDX_W;
    localparam int CW = lkv_pkg::CAP_W;

    logic [lkv_pkg::KEY_W-1:0] entry_key_mem   [N];
    logic [lkv_pkg::VAL_W-1:0] entry_value_mem [N];

    logic [N-1:0]  valid_reg;
    logic [N-1:0]  valid_next;
    logic [IW-1:0] rank_reg  [N];
    logic [IW-1:0] rank_next [N];
    logic [CW-1:0] occ_reg;
    logic [CW-1:0] occ_next;

    logic                      kind_reg;
    logic [lkv_pkg::KEY_W-1:0] key_reg;
    logic [lkv_pkg::VAL_W-1:0] value_reg;
    logic [IW-1:0]             idx_reg;

    logic                      match_found_reg;
    logic [IW-1:0]             match_slot_reg;
    logic [IW-1:0]             match_rank_reg;
    logic [lkv_pkg::VAL_W-1:0] match_value_reg;
    logic                      free_found_reg;
    logic [IW-1:0]             free_slot_reg;

    logic                      out_valid_reg;
    logic                      out_hit_reg;
    logic [lkv_pkg::VAL_W-1:0] out_value_reg;

    logic [CW-1:0] cap_eff;
    logic [CW-1:0] cap_m1;
    logic          evict_mode;
    logic          scan_free;
    logic          is_put;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;

    always_comb begin
        priority if (capacity == '0) begin
            cap_eff = CW'(1);
        end else if (capacity > CW'(N)) begin
            cap_eff = CW'(N);
        end else begin
            cap_eff = capacity;
        end
    end

    assign cap_m1     = cap_eff - CW'(1);
    assign evict_mode = (occ_reg >= cap_eff);
    assign is_put     = (kind_reg == lkv_pkg::KIND_PUT);

    assign scan_free = !valid_reg[idx_reg]
                     || (evict_mode && (CW'(rank_reg[idx_reg]) >= cap_m1));

    assign sts.scan_last = (idx_reg == IW'(N - 1));
    assign sts.is_get    = (kind_reg == lkv_pkg::KIND_GET);
    assign sts.out_busy  = out_valid_reg && !out_ready;

    // rank and valid update, one independent compare per entry
    always_comb begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        for (int i = 0; i < N; i++) begin
            rank_next[i] = rank_reg[i];
        end
        if (cmd.commit) begin
            if (match_found_reg) begin
                for (int i = 0; i < N; i++) begin
                    if (valid_reg[i] && (IW'(i) != match_slot_reg)
                        && (rank_reg[i] < match_rank_reg)) begin
                        rank_next[i] = rank_reg[i] + IW'(1);
                    end
                end
                rank_next[match_slot_reg] = '0;
            end else if (is_put) begin
                for (int i = 0; i < N; i++) begin
                    if (valid_reg[i]) begin
                        if (evict_mode && (CW'(rank_reg[i]) >= cap_m1)) begin
                            valid_next[i] = 1'b0;
                        end else begin
                            rank_next[i] = rank_reg[i] + IW'(1);
                        end
                    end
                end
                valid_next[free_slot_reg] = 1'b1;
                rank_next[free_slot_reg]  = '0;
                occ_next = evict_mode ? cap_eff : occ_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            occ_reg   <= '0;
            for (int i = 0; i < N; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            for (int i = 0; i < N; i++) begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    assign mem_we    = cmd.commit && is_put && (match_found_reg || free_found_reg);
    assign mem_waddr = match_found_reg ? match_slot_reg : free_slot_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            entry_value_mem[mem_waddr] <= value_reg;
            if (!match_found_reg) begin
                entry_key_mem[mem_waddr] <= key_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg        <= in_kind;
            key_reg         <= in_key;
            value_reg       <= in_value;
            idx_reg         <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
        end else if (cmd.scan_step) begin
            idx_reg <= idx_reg + IW'(1);
            if (valid_reg[idx_reg] && (entry_key_mem[idx_reg] == key_reg)
                && !match_found_reg) begin
                match_found_reg <= 1'b1;
                match_slot_reg  <= idx_reg;
                match_rank_reg  <= rank_reg[idx_reg];
                match_value_reg <= entry_value_mem[idx_reg];
            end
            if (scan_free && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_slot_reg  <= idx_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit && sts.is_get) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && sts.is_get) begin
            out_hit_reg   <= match_found_reg;
            out_value_reg <= match_found_reg ? match_value_reg : lkv_pkg::MISS_VALUE;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_hit   = out_hit_reg;
    assign out_value = out_value_reg;

endmodule
